>>> rtl/snnc_pkg.sv
// shared types, constants and a helper for the som nearest node classifier
// no dependencies
`timescale 1ns / 1ps

package snnc_pkg;

  localparam int NODES       = 400;
  localparam int FEATURES    = 6;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int FEAT_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int BIT_W  = $clog2(WEIGHT_BITS);
  localparam int DIST_W = 19;
  localparam int ROW_W  = FEATURES * WEIGHT_BITS;

  localparam logic [WEIGHT_BITS-1:0] FULL = {WEIGHT_BITS{1'b1}};

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_SIGNAL = 2'd1;
  localparam logic [1:0] CMD_SPAN   = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [8:0]         index;
    logic signed [31:0] feature_0;
    logic signed [31:0] feature_1;
    logic signed [31:0] feature_2;
    logic signed [31:0] feature_3;
    logic signed [31:0] feature_4;
    logic signed [31:0] feature_5;
    logic signed [15:0] signal_value;
    logic signed [31:0] span_low;
    logic signed [31:0] span_high;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] predicted_signal;
    logic [8:0]         best_node;
    logic [18:0]        best_distance;
    logic               not_ready;
  } out_item_t;

  function automatic logic signed [31:0] feature_of(input in_item_t item,
                                                    input int f);
    logic signed [31:0] v;
    case (f)
      1:       v = item.feature_1;
      2:       v = item.feature_2;
      3:       v = item.feature_3;
      4:       v = item.feature_4;
      5:       v = item.feature_5;
      default: v = item.feature_0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/snnc_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module snnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/snnc_cmd_queue.sv
// two entry transaction queue between the front and the back
// depends on snnc_pkg
`timescale 1ns / 1ps

module snnc_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  snnc_pkg::in_item_t push_item,
  input  logic               pop,
  output logic               empty,
  output snnc_pkg::in_item_t head_item
);

  snnc_pkg::in_item_t slot_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/snnc_engine.sv
// back end: executes writes, scales features, scans the weight store and reads the best node's signal
// depends on snnc_pkg and snnc_ram
`timescale 1ns / 1ps

module snnc_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  snnc_pkg::in_item_t  q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output snnc_pkg::out_item_t out_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_SIG  = 3'd4;
  localparam logic [2:0] ST_SIGW = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       res_valid_r, res_valid_nxt;
  snnc_pkg::out_item_t res_r, res_nxt;
  logic       params_r, params_nxt;
  logic       weights_r, weights_nxt;
  snnc_pkg::in_item_t cur_r, cur_nxt;

  logic signed [31:0] min_r [snnc_pkg::FEATURES];
  logic signed [31:0] max_r [snnc_pkg::FEATURES];
  logic [snnc_pkg::WEIGHT_BITS-1:0] scaled_r [snnc_pkg::FEATURES];
  logic [snnc_pkg::WEIGHT_BITS-1:0] scaled_nxt [snnc_pkg::FEATURES];
  logic span_we;

  logic [snnc_pkg::FEAT_W-1:0]      f_r, f_nxt;
  logic [snnc_pkg::BIT_W-1:0]       bit_r, bit_nxt;
  logic [32:0]                      rem_r, rem_nxt;
  logic [32:0]                      den_r, den_nxt;
  logic [snnc_pkg::WEIGHT_BITS-1:0] quo_r, quo_nxt;

  logic [snnc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic [snnc_pkg::NODE_W-1:0] best_n_r, best_n_nxt;
  logic [snnc_pkg::NODE_W-1:0] rd_n_r, rd_n_nxt;
  logic [snnc_pkg::DIST_W-1:0] best_d_r, best_d_nxt;
  logic [snnc_pkg::DIST_W-1:0] row_dist;

  logic                        wram_we, sram_we;
  logic [snnc_pkg::NODE_W-1:0] wram_addr, sram_addr;
  logic [snnc_pkg::ROW_W-1:0]  wram_wdata, wram_rdata;
  logic [15:0]                 sram_rdata;

  logic signed [32:0] x_s, lo_s, hi_s, diff_s, span_s, diff_p, span_p;
  logic [33:0]        rem_sh;
  logic               take;
  logic               load_special;
  logic [snnc_pkg::WEIGHT_BITS-1:0] load_val;
  logic               feat_last;

  snnc_ram #(.WIDTH(snnc_pkg::ROW_W), .DEPTH(snnc_pkg::NODES)) u_weight_ram (
    .clk   (clk),
    .we    (wram_we),
    .addr  (wram_addr),
    .wdata (wram_wdata),
    .rdata (wram_rdata)
  );

  snnc_ram #(.WIDTH(16), .DEPTH(snnc_pkg::NODES)) u_signal_ram (
    .clk   (clk),
    .we    (sram_we),
    .addr  (sram_addr),
    .wdata (q_item.signal_value),
    .rdata (sram_rdata)
  );

  assign out_empty = !res_valid_r;
  assign out_item  = res_r;
  assign feat_last = (32'(f_r) == snnc_pkg::FEATURES - 1);

  // weight row from the low bits of each feature field
  always_comb begin
    wram_wdata = '0;
    for (int f = 0; f < snnc_pkg::FEATURES; f++) begin
      wram_wdata[f*snnc_pkg::WEIGHT_BITS +: snnc_pkg::WEIGHT_BITS] =
        snnc_pkg::WEIGHT_BITS'(snnc_pkg::feature_of(q_item, f));
    end
  end

  // l1 distance of the row just read
  always_comb begin
    logic [snnc_pkg::WEIGHT_BITS-1:0] w;
    row_dist = '0;
    for (int f = 0; f < snnc_pkg::FEATURES; f++) begin
      w = wram_rdata[f*snnc_pkg::WEIGHT_BITS +: snnc_pkg::WEIGHT_BITS];
      row_dist = row_dist + snnc_pkg::DIST_W'((w > scaled_r[f]) ? (w - scaled_r[f])
                                                                 : (scaled_r[f] - w));
    end
  end

  // scaling set-up for the current feature
  always_comb begin
    x_s    = 33'(snnc_pkg::feature_of(cur_r, int'(f_r)));
    lo_s   = 33'(min_r[f_r]);
    hi_s   = 33'(max_r[f_r]);
    diff_s = x_s - lo_s;
    span_s = hi_s - lo_s;
    diff_p = span_s[32] ? -diff_s : diff_s;
    span_p = span_s[32] ? -span_s : span_s;
    load_special = 1'b1;
    load_val     = '0;
    if (span_s == '0) begin
      load_val = (diff_s > 0) ? snnc_pkg::FULL : '0;
    end else if (diff_p <= 0) begin
      load_val = '0;
    end else if (diff_p >= span_p) begin
      load_val = snnc_pkg::FULL;
    end else begin
      load_special = 1'b0;
    end
    rem_sh = {rem_r, 1'b0};
    take   = (rem_sh >= {1'b0, den_r});
  end

  always_comb begin
    state_nxt     = state_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    params_nxt    = params_r;
    weights_nxt   = weights_r;
    cur_nxt       = cur_r;
    scaled_nxt    = scaled_r;
    f_nxt         = f_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    rd_v_nxt      = 1'b0;
    rd_n_nxt      = rd_n_r;
    best_n_nxt    = best_n_r;
    best_d_nxt    = best_d_r;
    q_pop         = 1'b0;
    span_we       = 1'b0;
    wram_we       = 1'b0;
    sram_we       = 1'b0;
    wram_addr     = q_item.index[snnc_pkg::NODE_W-1:0];
    sram_addr     = q_item.index[snnc_pkg::NODE_W-1:0];

    if (res_valid_r && out_pop) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty && !res_valid_r) begin
          q_pop         = 1'b1;
          cur_nxt       = q_item;
          res_nxt       = '0;
          res_valid_nxt = 1'b1;
          case (q_item.command)
            snnc_pkg::CMD_WEIGHT: begin
              if (32'(q_item.index) < snnc_pkg::NODES) begin
                wram_we     = 1'b1;
                weights_nxt = 1'b1;
              end
            end
            snnc_pkg::CMD_SIGNAL: begin
              sram_we = (32'(q_item.index) < snnc_pkg::NODES);
            end
            snnc_pkg::CMD_SPAN: begin
              if (32'(q_item.index) < snnc_pkg::FEATURES) begin
                span_we    = 1'b1;
                params_nxt = 1'b1;
              end
            end
            default: begin
              if (!params_r || !weights_r) begin
                res_nxt.not_ready = 1'b1;
              end else begin
                res_valid_nxt = 1'b0;
                f_nxt         = '0;
                state_nxt     = ST_LOAD;
              end
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (load_special) begin
          scaled_nxt[f_r] = load_val;
          if (feat_last) begin
            cnt_nxt    = '0;
            best_d_nxt = '1;
            best_n_nxt = '0;
            state_nxt  = ST_SCAN;
          end else begin
            f_nxt = f_r + 1'b1;
          end
        end else begin
          rem_nxt   = diff_p;
          den_nxt   = span_p;
          bit_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = take ? 33'(rem_sh - {1'b0, den_r}) : rem_sh[32:0];
        quo_nxt = {quo_r[snnc_pkg::WEIGHT_BITS-2:0], take};
        bit_nxt = bit_r + 1'b1;
        if (32'(bit_r) == snnc_pkg::WEIGHT_BITS - 1) begin
          scaled_nxt[f_r] = {quo_r[snnc_pkg::WEIGHT_BITS-2:0], take};
          if (feat_last) begin
            cnt_nxt    = '0;
            best_d_nxt = '1;
            best_n_nxt = '0;
            state_nxt  = ST_SCAN;
          end else begin
            f_nxt     = f_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_SCAN: begin
        wram_addr = cnt_r[snnc_pkg::NODE_W-1:0];
        if (32'(cnt_r) < snnc_pkg::NODES) begin
          rd_v_nxt = 1'b1;
          rd_n_nxt = cnt_r[snnc_pkg::NODE_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (rd_v_r && (row_dist < best_d_r)) begin
          best_d_nxt = row_dist;
          best_n_nxt = rd_n_r;
        end
        if ((32'(cnt_r) == snnc_pkg::NODES) && !rd_v_r) begin
          state_nxt = ST_SIG;
        end
      end
      ST_SIG: begin
        sram_addr = best_n_r;
        state_nxt = ST_SIGW;
      end
      ST_SIGW: begin
        res_nxt.predicted_signal = sram_rdata;
        res_nxt.best_node        = 9'(best_n_r);
        res_nxt.best_distance    = best_d_r;
        res_nxt.not_ready        = 1'b0;
        res_valid_nxt            = 1'b1;
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      params_r    <= 1'b0;
      weights_r   <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      params_r    <= params_nxt;
      weights_r   <= weights_nxt;
      rd_v_r      <= rd_v_nxt;
    end
    res_r    <= res_nxt;
    cur_r    <= cur_nxt;
    scaled_r <= scaled_nxt;
    f_r      <= f_nxt;
    bit_r    <= bit_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    rd_n_r   <= rd_n_nxt;
    best_n_r <= best_n_nxt;
    best_d_r <= best_d_nxt;
    if (span_we) begin
      min_r[q_item.index[snnc_pkg::FEAT_W-1:0]] <= q_item.span_low;
      max_r[q_item.index[snnc_pkg::FEAT_W-1:0]] <= q_item.span_high;
    end
  end

endmodule

>>> rtl/som_nearest_node_classifier.sv
// top level: command queue in front of the engine; uses snnc_pkg, snnc_cmd_queue, snnc_engine
// flow: a write passes a queue slot, then the result register once the last result is popped;
// a query takes, per feature, a load and, unless the value clamps, 16 quotient bits, then scans
// one weight row per cycle through the registered ram read, then reads the best node's signal
// throughput: one transaction in the engine, the next starts the cycle after the result pop
// reset: synchronous active low rst_n clears the queue, the result and the loaded flags
`timescale 1ns / 1ps

module som_nearest_node_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  snnc_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output snnc_pkg::out_item_t out_item
);

  logic               q_empty, q_pop;
  snnc_pkg::in_item_t q_item;

  snnc_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .push_item (in_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_item)
  );

  snnc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.not_ready) |->
      (out_item.best_node == '0 && out_item.predicted_signal == '0 &&
       out_item.best_distance == '0))
    else $error("not ready result carries data");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.best_distance <= 19'd393210))
    else $error("distance out of range");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (!in_full && out_empty))
    else $error("queue or result not cleared by reset");

endmodule
